// ===== src/rbd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rbd_pkg;

    // Field widths fixed by the item formats.
    localparam int OP_W    = 2;
    localparam int SYM_W   = 8;
    localparam int FREQ_W  = 13;
    localparam int CUM_W   = 12;
    localparam int BYTE_W  = 8;
    localparam int STATE_W = 32;
    localparam int COUNT_W = 25;

    // Slot walk counter: wide enough for cumulative start plus frequency
    // and for the largest slot count.
    localparam int FILL_W = 16;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_BYTE   = 2'd1,
        OP_DECODE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

endpackage

`default_nettype wire

// ===== src/rbd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/rans_byte_decoder_top.sv =====
// From request acceptance to result valid: a byte item, an unknown operation or a refused
// decode goes straight to the result state; a decode passes two dependent RAM reads, the
// multiply stage and the add stage; a load writes n slots, one slot per cycle, first. The
// result state waits while the output register is held. A new request is taken in the
// cycle after the previous result is registered. Reset clears the coder state, decoded
// count, plane length and control; the RAMs are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module rans_byte_decoder_top #(
    parameter int SCALE_BITS        = 12,
    parameter int SYMBOL_COUNT      = 256,
    parameter int LOWER_BOUND_SHIFT = 23
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,

    // Request channel.
    input  wire logic                       item_valid,
    output logic                            item_stall,
    input  wire logic [rbd_pkg::OP_W-1:0]   operation,
    input  wire logic [rbd_pkg::SYM_W-1:0]  symbol_index,
    input  wire logic [rbd_pkg::FREQ_W-1:0] frequency,
    input  wire logic [rbd_pkg::CUM_W-1:0]  cumulative_start,
    input  wire logic [rbd_pkg::BYTE_W-1:0] stream_byte,

    // Result channel.
    output logic                            result_valid,
    input  wire logic                       result_stall,
    output logic      [rbd_pkg::SYM_W-1:0]  decoded_symbol,
    output logic                            refill_needed,
    output logic                            last_symbol,

    // Plane length register write.
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [rbd_pkg::COUNT_W-1:0] cfg_data
);

    localparam int SYM_AW  = $clog2(SYMBOL_COUNT);
    localparam int TAB_W   = rbd_pkg::FREQ_W + rbd_pkg::CUM_W;
    localparam int HI_W    = rbd_pkg::STATE_W - SCALE_BITS;
    localparam int MUL_W   = rbd_pkg::FREQ_W + HI_W;
    localparam logic [rbd_pkg::FILL_W-1:0] SLOT_LIMIT =
        rbd_pkg::FILL_W'(1 << SCALE_BITS);
    localparam logic [rbd_pkg::SYM_W:0] SYM_LIMIT = (rbd_pkg::SYM_W + 1)'(SYMBOL_COUNT);
    localparam logic [rbd_pkg::STATE_W-1:0] LOWER_BOUND =
        rbd_pkg::STATE_W'(1) << LOWER_BOUND_SHIFT;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_DEC_SLOT,
        ST_DEC_TAB,
        ST_DEC_MUL,
        ST_RESULT
    } state_t;

    state_t state_reg;

    // Architectural state kept in flip-flops.
    logic [rbd_pkg::STATE_W-1:0] coder_state_reg;
    logic [rbd_pkg::COUNT_W-1:0] decoded_count_reg;
    logic [rbd_pkg::COUNT_W-1:0] plane_length_reg;

    // Per-request working registers.
    logic [rbd_pkg::FILL_W-1:0]  fill_idx_reg;
    logic [rbd_pkg::FILL_W-1:0]  fill_end_reg;
    logic [rbd_pkg::SYM_W-1:0]   fill_sym_reg;
    logic [rbd_pkg::STATE_W-1:0] product_reg;
    logic [rbd_pkg::CUM_W-1:0]   cum_reg;
    logic [rbd_pkg::SYM_W-1:0]   res_sym_reg;
    logic                        res_last_reg;

    // Output register.
    logic                        result_valid_reg;
    logic [rbd_pkg::SYM_W-1:0]   decoded_symbol_reg;
    logic                        refill_needed_reg;
    logic                        last_symbol_reg;

    logic item_accept;
    logic cfg_write;
    logic out_free;
    logic result_load;

    assign item_accept = item_valid && !item_stall;
    assign cfg_write   = cfg_valid && cfg_ready;
    // The output register can take a new result when it is empty or being drained.
    assign out_free    = !result_valid_reg || !result_stall;
    // A finished request moves into the output register this cycle.
    assign result_load = (state_reg == ST_RESULT) && out_free;

    assign item_stall = (state_reg != ST_IDLE);
    // The register is only written between requests, which keeps the clear of
    // the decoded count away from the decode increment.
    assign cfg_ready  = (state_reg == ST_IDLE);

    assign result_valid   = result_valid_reg;
    assign decoded_symbol = decoded_symbol_reg;
    assign refill_needed  = refill_needed_reg;
    assign last_symbol    = last_symbol_reg;

    // ------------------------------------------------------------------
    // Load request decode: range check and the clipped end of the slot run.
    // ------------------------------------------------------------------
    logic                       load_in_range;
    logic [rbd_pkg::FILL_W-1:0] load_end_raw;
    logic [rbd_pkg::FILL_W-1:0] load_end;

    assign load_in_range = ({1'b0, symbol_index} < SYM_LIMIT);
    assign load_end_raw  = rbd_pkg::FILL_W'(cumulative_start) + rbd_pkg::FILL_W'(frequency);
    assign load_end      = (load_end_raw > SLOT_LIMIT) ? SLOT_LIMIT : load_end_raw;

    // ------------------------------------------------------------------
    // Slot-to-symbol RAM: written by the slot walk, read at the state's
    // low bits. The state does not move between the read and its use.
    // ------------------------------------------------------------------
    logic                      slot_we;
    logic [rbd_pkg::SYM_W-1:0] slot_rdata;

    assign slot_we = (state_reg == ST_FILL) && (fill_idx_reg < fill_end_reg);

    rbd_ram #(
        .WIDTH (rbd_pkg::SYM_W),
        .DEPTH (1 << SCALE_BITS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (fill_idx_reg[SCALE_BITS-1:0]),
        .wdata (fill_sym_reg),
        .raddr (coder_state_reg[SCALE_BITS-1:0]),
        .rdata (slot_rdata)
    );

    // ------------------------------------------------------------------
    // Frequency and cumulative RAM, one word per symbol.
    // ------------------------------------------------------------------
    logic              tab_we;
    logic [SYM_AW-1:0] tab_raddr;
    logic [TAB_W-1:0]  tab_rdata;
    logic [rbd_pkg::FREQ_W-1:0] tab_freq;
    logic [rbd_pkg::CUM_W-1:0]  tab_cum;

    assign tab_we = item_accept && (operation == rbd_pkg::OP_LOAD) && load_in_range;
    // A symbol code beyond the alphabet indexes entry zero.
    assign tab_raddr = ({1'b0, slot_rdata} < SYM_LIMIT) ? slot_rdata[SYM_AW-1:0] : '0;
    assign tab_freq  = tab_rdata[TAB_W-1 -: rbd_pkg::FREQ_W];
    assign tab_cum   = tab_rdata[rbd_pkg::CUM_W-1:0];

    rbd_ram #(
        .WIDTH (TAB_W),
        .DEPTH (SYMBOL_COUNT)
    ) u_tab_ram (
        .clk   (clk),
        .we    (tab_we),
        .waddr (symbol_index[SYM_AW-1:0]),
        .wdata ({frequency, cumulative_start}),
        .raddr (tab_raddr),
        .rdata (tab_rdata)
    );

    // ------------------------------------------------------------------
    // State update datapath: multiply in one stage, add and subtract in
    // the next. Everything wraps modulo 2^32.
    // ------------------------------------------------------------------
    logic [HI_W-1:0]             state_hi;
    logic [MUL_W-1:0]            mul_full;
    logic [rbd_pkg::STATE_W-1:0] dec_state_next;
    logic [rbd_pkg::COUNT_W-1:0] count_inc;
    logic                        decode_ok;

    assign state_hi       = coder_state_reg[rbd_pkg::STATE_W-1:SCALE_BITS];
    assign mul_full       = tab_freq * state_hi;
    assign dec_state_next = product_reg
                          + rbd_pkg::STATE_W'(coder_state_reg[SCALE_BITS-1:0])
                          - rbd_pkg::STATE_W'(cum_reg);
    assign count_inc      = decoded_count_reg + rbd_pkg::COUNT_W'(1);
    assign decode_ok      = (decoded_count_reg < plane_length_reg);

    // ------------------------------------------------------------------
    // Sequencer and output register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            coder_state_reg    <= '0;
            decoded_count_reg  <= '0;
            plane_length_reg   <= '0;
            fill_idx_reg       <= '0;
            fill_end_reg       <= '0;
            fill_sym_reg       <= '0;
            product_reg        <= '0;
            cum_reg            <= '0;
            res_sym_reg        <= '0;
            res_last_reg       <= 1'b0;
            result_valid_reg   <= 1'b0;
            decoded_symbol_reg <= '0;
            refill_needed_reg  <= 1'b0;
            last_symbol_reg    <= 1'b0;
        end
        else
        begin
            if (result_valid_reg && !result_stall && !result_load)
            begin
                result_valid_reg <= 1'b0;
            end

            if (cfg_write)
            begin
                plane_length_reg  <= cfg_data;
                decoded_count_reg <= '0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (item_accept)
                    begin
                        res_sym_reg  <= '0;
                        res_last_reg <= 1'b0;
                        case (operation)
                            rbd_pkg::OP_LOAD:
                            begin
                                fill_idx_reg <= rbd_pkg::FILL_W'(cumulative_start);
                                fill_end_reg <= load_in_range ? load_end : '0;
                                fill_sym_reg <= symbol_index;
                                state_reg    <= ST_FILL;
                            end
                            rbd_pkg::OP_BYTE:
                            begin
                                coder_state_reg <= {
                                    coder_state_reg[rbd_pkg::STATE_W-rbd_pkg::BYTE_W-1:0],
                                    stream_byte};
                                state_reg       <= ST_RESULT;
                            end
                            rbd_pkg::OP_DECODE:
                            begin
                                // The slot read is issued this cycle.
                                state_reg <= decode_ok ? ST_DEC_SLOT : ST_RESULT;
                            end
                            default:
                            begin
                                state_reg <= ST_RESULT;
                            end
                        endcase
                    end
                end

                ST_FILL:
                begin
                    if (fill_idx_reg < fill_end_reg)
                    begin
                        fill_idx_reg <= fill_idx_reg + rbd_pkg::FILL_W'(1);
                    end
                    else
                    begin
                        state_reg <= ST_RESULT;
                    end
                end

                ST_DEC_SLOT:
                begin
                    // Symbol arrives; its table word is read this cycle.
                    res_sym_reg <= slot_rdata;
                    state_reg   <= ST_DEC_TAB;
                end

                ST_DEC_TAB:
                begin
                    product_reg <= rbd_pkg::STATE_W'(mul_full);
                    cum_reg     <= tab_cum;
                    state_reg   <= ST_DEC_MUL;
                end

                ST_DEC_MUL:
                begin
                    coder_state_reg   <= dec_state_next;
                    decoded_count_reg <= count_inc;
                    res_last_reg      <= (count_inc == plane_length_reg);
                    state_reg         <= ST_RESULT;
                end

                ST_RESULT:
                begin
                    if (out_free)
                    begin
                        result_valid_reg   <= 1'b1;
                        decoded_symbol_reg <= res_sym_reg;
                        refill_needed_reg  <= (coder_state_reg < LOWER_BOUND);
                        last_symbol_reg    <= res_last_reg;
                        state_reg          <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // An accepted request always leaves the idle state.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_accept |=> (state_reg != ST_IDLE))
    else $error("accepted request did not start processing");

    // A new result only appears as the sequencer leaves the result state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == ST_RESULT))
    else $error("result raised outside the result state");

    // The slot walk never writes past its clipped end or the table size.
    assert property (@(posedge clk) disable iff (!rst_n)
        slot_we |-> (fill_idx_reg < SLOT_LIMIT))
    else $error("slot write beyond table");

    // A register write restarts the plane.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> (decoded_count_reg == '0))
    else $error("decoded count not cleared by register write");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    // Block constants as built with default parameters.
    localparam int          SLOT_BITS    = 12;
    localparam int          SLOT_COUNT   = 1 << SLOT_BITS;
    localparam logic [31:0] LOWER_BOUND  = 32'h0080_0000;
    localparam logic [24:0] MAX_PLANE    = 25'd16777216;

    // Run shape. The stall limit has to cover a load that walks all slots
    // plus the long receiver hold-off with plenty of margin.
    localparam int TARGET_REQUESTS = 700;
    localparam int CALM_TAIL       = 80;
    localparam int HOLD_AT         = 150;
    localparam int HOLD_CYCLES     = 200;
    localparam int STALL_LIMIT     = 20000;
    localparam int DRAIN_CYCLES    = 20;

    // One request as presented on the input channel.
    typedef struct packed {
        rbd_pkg::op_t op;
        logic [7:0]   sym;
        logic [12:0]  freq;
        logic [11:0]  cum;
        logic [7:0]   sbyte;
    } request_t;

    // One result as seen on the output channel.
    typedef struct packed {
        logic [7:0] sym;
        logic       refill;
        logic       last;
    } symbol_out_t;

    // Directed rows either send a request or rewrite the plane length.
    typedef enum bit {
        ROW_REQUEST   = 1'b0,
        ROW_PLANE_LEN = 1'b1
    } row_kind_t;

    typedef struct {
        row_kind_t    kind;
        logic [24:0]  cfg_val;
        rbd_pkg::op_t op;
        logic [7:0]   sym;
        logic [12:0]  freq;
        logic [11:0]  cum;
        logic [7:0]   sbyte;
        bit           typed;
        logic [7:0]   e_sym;
        logic         e_refill;
        logic         e_last;
    } directed_row_t;

    logic                         clk              = 1'b0;
    logic                         rst_n            = 1'b0;
    logic                         item_valid       = 1'b0;
    logic                         item_stall;
    logic [rbd_pkg::OP_W-1:0]     operation        = '0;
    logic [rbd_pkg::SYM_W-1:0]    symbol_index     = '0;
    logic [rbd_pkg::FREQ_W-1:0]   frequency        = '0;
    logic [rbd_pkg::CUM_W-1:0]    cumulative_start = '0;
    logic [rbd_pkg::BYTE_W-1:0]   stream_byte      = '0;
    logic                         result_valid;
    logic                         result_stall     = 1'b0;
    logic [rbd_pkg::SYM_W-1:0]    decoded_symbol;
    logic                         refill_needed;
    logic                         last_symbol;
    logic                         cfg_valid        = 1'b0;
    logic                         cfg_ready;
    logic [rbd_pkg::COUNT_W-1:0]  cfg_data         = '0;

    rans_byte_decoder_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item_stall       (item_stall),
        .operation        (operation),
        .symbol_index     (symbol_index),
        .frequency        (frequency),
        .cumulative_start (cumulative_start),
        .stream_byte      (stream_byte),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .decoded_symbol   (decoded_symbol),
        .refill_needed    (refill_needed),
        .last_symbol      (last_symbol),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data)
    );

    always #5 clk = ~clk;

    // Decoder shadow: slot owners, per-symbol frequency and start, the coder
    // state, the plane progress and the plane length register.
    logic [7:0]  slot_owner [SLOT_COUNT];
    logic [12:0] sym_freq   [256];
    logic [11:0] sym_cum    [256];
    logic [31:0] coder_state  = '0;
    logic [24:0] symbols_done = '0;
    logic [24:0] plane_len    = '0;

    // Symbols still owed by the block, oldest first.
    symbol_out_t pending_symbols [$];

    int  requests_sent = 0;
    int  results_seen  = 0;
    int  mismatches    = 0;
    int  loads_seen    = 0;
    int  bytes_seen    = 0;
    int  decodes_seen  = 0;
    int  refused_seen  = 0;
    int  others_seen   = 0;
    int  lasts_seen    = 0;
    int  refills_seen  = 0;
    int  plane_writes  = 0;
    int  stall_left    = 0;
    int  idle_cycles   = 0;
    bit  held_off      = 1'b0;
    bit  quiet         = 1'b0;

    // Directed stimulus. The opening rows run before any table exists, so
    // the only decode there is refused by the zero plane length. One load
    // then claims every slot, which keeps all later decodes on written
    // entries. Rows marked typed carry their result; the rest go through
    // the shadow model.
    directed_row_t directed_rows [25] = '{
        // Refused decode, unknown operation and a first byte straight out of reset.
        '{ROW_REQUEST, 25'd0, rbd_pkg::OP_DECODE, 8'h00, 13'd0, 12'd0, 8'h00, 1, 8'h00, 1, 0},
        '{ROW_REQUEST, 25'd0, rbd_pkg::OP_NONE, 8'h00, 13'd0, 12'd0, 8'h00, 1, 8'h00, 1, 0},
        '{ROW_REQUEST, 25'd0, rbd_pkg::OP_BYTE, 8'h00, 13'd0, 12'd0, 8'hFF, 1, 8'h00, 1, 0},
        // Full-scale symbol, zero frequency, slots running past the scale.
        '{ROW_REQUEST, 25'd0, rbd_pkg::OP_LOAD, 8'hAA, 13'd4096, 12'd0, 8'h00, 1, 8'h00, 1, 0},
        '{ROW_REQUEST, 25'd0, rbd_pkg::OP_LOAD, 8'h55, 13'd0, 12'd4095, 8'h00, 1, 8'h00, 1, 0},
        '{ROW_REQUEST, 25'd0, rbd_pkg::OP_LOAD, 8'hFF, 13'd8191, 12'd4095, 8'h00, 1, 8'h00, 1, 0},
        '{ROW_REQUEST, 25'd0, rbd_pkg::OP_LOAD, 8'h00, 13'd1, 12'd0, 8'h00, 1, 8'h00, 1, 0},
        '{ROW_REQUEST, 25'd0, rbd_pkg::OP_LOAD, 8'h01, 13'd4, 12'd4094, 8'h00, 1, 8'h00, 1, 0},
        // Start bytes; the state clears the lower bound on the second one.
        '{ROW_REQUEST, 25'd0, rbd_pkg::OP_BYTE, 8'h00, 13'd0, 12'd0, 8'h00, 1, 8'h00, 1, 0},
        '{ROW_REQUEST, 25'd0, rbd_pkg::OP_BYTE, 8'h00, 13'd0, 12'd0, 8'hFF, 1, 8'h00, 0, 0},
        '{ROW_REQUEST, 25'd0, rbd_pkg::OP_BYTE, 8'h00, 13'd0, 12'd0, 8'hFF, 1, 8'h00, 0, 0},
        // Two-symbol plane, then a decode past its end.
        '{ROW_PLANE_LEN, 25'd2, rbd_pkg::OP_NONE, 8'h00, 13'd0, 12'd0, 8'h00, 0, 8'h00, 0, 0},
        '{ROW_REQUEST, 25'd0, rbd_pkg::OP_DECODE, 8'h00, 13'd0, 12'd0, 8'h00, 0, 8'h00, 0, 0},
        '{ROW_REQUEST, 25'd0, rbd_pkg::OP_DECODE, 8'h00, 13'd0, 12'd0, 8'h00, 0, 8'h00, 0, 0},
        '{ROW_REQUEST, 25'd0, rbd_pkg::OP_DECODE, 8'h00, 13'd0, 12'd0, 8'h00, 0, 8'h00, 0, 0},
        // Largest plane; the state update wraps past 32 bits.
        '{ROW_PLANE_LEN, MAX_PLANE, rbd_pkg::OP_NONE, 8'h00, 13'd0, 12'd0, 8'h00, 0, 8'h00, 0, 0},
        '{ROW_REQUEST, 25'd0, rbd_pkg::OP_LOAD, 8'h80, 13'd8191, 12'd0, 8'h00, 0, 8'h00, 0, 0},
        '{ROW_REQUEST, 25'd0, rbd_pkg::OP_BYTE, 8'h00, 13'd0, 12'd0, 8'hFF, 0, 8'h00, 0, 0},
        '{ROW_REQUEST, 25'd0, rbd_pkg::OP_BYTE, 8'h00, 13'd0, 12'd0, 8'hFF, 0, 8'h00, 0, 0},
        '{ROW_REQUEST, 25'd0, rbd_pkg::OP_BYTE, 8'h00, 13'd0, 12'd0, 8'hFF, 0, 8'h00, 0, 0},
        '{ROW_REQUEST, 25'd0, rbd_pkg::OP_BYTE, 8'h00, 13'd0, 12'd0, 8'hFF, 1, 8'h00, 0, 0},
        '{ROW_REQUEST, 25'd0, rbd_pkg::OP_DECODE, 8'h00, 13'd0, 12'd0, 8'h00, 0, 8'h00, 0, 0},
        // Moving the start of a symbol that still owns every slot makes
        // slot minus start go negative.
        '{ROW_REQUEST, 25'd0, rbd_pkg::OP_LOAD, 8'h80, 13'd1, 12'd4095, 8'h00, 0, 8'h00, 0, 0},
        '{ROW_REQUEST, 25'd0, rbd_pkg::OP_DECODE, 8'h00, 13'd0, 12'd0, 8'h00, 0, 8'h00, 0, 0},
        '{ROW_REQUEST, 25'd0, rbd_pkg::OP_NONE, 8'h00, 13'd0, 12'd0, 8'h00, 0, 8'h00, 0, 0}
    };

    function automatic request_t make_request(rbd_pkg::op_t op, logic [7:0] sym,
                                              logic [12:0] freq, logic [11:0] cum,
                                              logic [7:0] sbyte);
        request_t req;
        req.op    = op;
        req.sym   = sym;
        req.freq  = freq;
        req.cum   = cum;
        req.sbyte = sbyte;
        return req;
    endfunction

    // Applies one accepted request to the shadow decoder and returns the
    // symbol it must produce.
    function automatic symbol_out_t advance_decoder(request_t req);
        symbol_out_t  res;
        int unsigned  stop;
        int unsigned  k;
        logic [11:0]  slot;
        logic [7:0]   owner;
        logic [63:0]  acc;
        res = '0;
        case (req.op)
            rbd_pkg::OP_LOAD: begin
                loads_seen++;
                sym_freq[req.sym] = req.freq;
                sym_cum[req.sym]  = req.cum;
                // Slots beyond the scale are simply dropped.
                stop = req.cum + req.freq;
                if (stop > SLOT_COUNT)
                    stop = SLOT_COUNT;
                for (k = req.cum; k < stop; k++)
                    slot_owner[k] = req.sym;
            end
            rbd_pkg::OP_BYTE: begin
                bytes_seen++;
                coder_state = {coder_state[23:0], req.sbyte};
            end
            rbd_pkg::OP_DECODE: begin
                decodes_seen++;
                if (symbols_done < plane_len) begin
                    slot  = coder_state[SLOT_BITS-1:0];
                    owner = slot_owner[slot];
                    acc   = 64'(sym_freq[owner]) * 64'(coder_state >> SLOT_BITS)
                            + 64'(slot) - 64'(sym_cum[owner]);
                    coder_state  = acc[31:0];
                    symbols_done = symbols_done + 25'd1;
                    res.sym  = owner;
                    res.last = (symbols_done == plane_len);
                end else begin
                    refused_seen++;
                end
            end
            default: others_seen++;
        endcase
        res.refill = (coder_state < LOWER_BOUND);
        if (res.refill)
            refills_seen++;
        if (res.last)
            lasts_seen++;
        return res;
    endfunction

    // Offers one request, holds it until the block takes it, then books the
    // symbol it owes. Valid is left high so back-to-back requests need no
    // second assignment within the acceptance step.
    task automatic send_request(input request_t req, input bit typed = 1'b0,
                                input symbol_out_t typed_out = '0);
        symbol_out_t predicted;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        item_valid       <= 1'b1;
        operation        <= req.op;
        symbol_index     <= req.sym;
        frequency        <= req.freq;
        cumulative_start <= req.cum;
        stream_byte      <= req.sbyte;
        do @(posedge clk); while (item_stall);
        predicted = advance_decoder(req);
        pending_symbols = {pending_symbols, (typed ? typed_out : predicted)};
        requests_sent++;
        if (requests_sent >= TARGET_REQUESTS - CALM_TAIL)
            quiet = 1'b1;
    endtask

    // The plane length may only change while the block is idle, so drain
    // every owed symbol first and leave a few cycles of slack.
    task automatic write_plane_length(input logic [24:0] len);
        item_valid <= 1'b0;
        while (pending_symbols.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        plane_len    = len;
        symbols_done = '0;
        plane_writes++;
    endtask

    // Feeds stream bytes while the state sits below the lower bound, as a
    // host draining the compressed stream would. Four bytes always suffice
    // unless the stream itself is mostly zeros.
    task automatic refill_state();
        int fed;
        fed = 0;
        while (coder_state < LOWER_BOUND && fed < 4) begin
            send_request(make_request(rbd_pkg::OP_BYTE, 8'h00, 13'd0, 12'd0,
                                      8'($urandom_range(0, 255))));
            fed++;
        end
    endtask

    // A table of one to eight symbols whose frequencies add up to the scale,
    // so every slot is owned and every decode follows real coder behavior.
    task automatic load_random_table();
        int unsigned parts;
        int unsigned cum;
        int unsigned f;
        int unsigned i;
        parts = $urandom_range(1, 8);
        cum   = 0;
        for (i = 0; i < parts; i++) begin
            if (i == parts - 1)
                f = SLOT_COUNT - cum;
            else
                f = $urandom_range(1, SLOT_COUNT - cum - (parts - 1 - i));
            send_request(make_request(rbd_pkg::OP_LOAD, 8'($urandom_range(0, 255)), 13'(f),
                                      12'(cum), 8'h00));
            cum += f;
        end
    endtask

    // Anything the fields allow: loads with odd frequencies and starts,
    // loose bytes, decodes at arbitrary points and unknown operations.
    task automatic send_noise();
        send_request(make_request(rbd_pkg::op_t'($urandom_range(0, 3)),
                                  8'($urandom_range(0, 255)),
                                  13'($urandom_range(0, 8191)), 12'($urandom_range(0, 4095)),
                                  8'($urandom_range(0, 255))));
    endtask

    // One plane: a fresh length, sometimes a fresh table, the four start bytes,
    // then decodes with refills and some noise, up to just past a short plane's end.
    task automatic play_plane();
        int unsigned pick;
        int unsigned decodes;
        logic [24:0] len;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            len = '0;
        else if (pick == 1)
            len = MAX_PLANE;
        else if (pick == 2)
            len = 25'($urandom_range(41, 16777216));
        else
            len = 25'($urandom_range(1, 30));
        write_plane_length(len);
        if ($urandom_range(0, 2) == 0)
            load_random_table();
        repeat (4)
            send_request(make_request(rbd_pkg::OP_BYTE, 8'h00, 13'd0, 12'd0,
                                      8'($urandom_range(0, 255))));
        refill_state();
        decodes = (len > 30 ? 30 : int'(len)) + $urandom_range(0, 2);
        repeat (decodes) begin
            send_request(make_request(rbd_pkg::OP_DECODE, 8'h00, 13'd0, 12'd0, 8'h00));
            refill_state();
            if ($urandom_range(0, 19) == 0)
                send_noise();
        end
    endtask

    // Result side: check each taken symbol against the oldest owed one and
    // drive random stall bursts, plus one long hold-off so the block backs
    // up into its input.
    task automatic check_symbol_out();
        symbol_out_t owed;
        results_seen++;
        if (pending_symbols.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result: symbol %0d refill %0d last %0d",
                     $time, decoded_symbol, refill_needed, last_symbol);
        end else begin
            owed = pending_symbols.pop_front();
            if (decoded_symbol !== owed.sym) begin
                mismatches++;
                $display("%0t: decoded_symbol expected %0d actual %0d",
                         $time, owed.sym, decoded_symbol);
            end
            if (refill_needed !== owed.refill) begin
                mismatches++;
                $display("%0t: refill_needed expected %0d actual %0d",
                         $time, owed.refill, refill_needed);
            end
            if (last_symbol !== owed.last) begin
                mismatches++;
                $display("%0t: last_symbol expected %0d actual %0d",
                         $time, owed.last, last_symbol);
            end
        end
    endtask

    always @(posedge clk) begin
        if (result_valid && !result_stall)
            check_symbol_out();
        if (!held_off && results_seen == HOLD_AT) begin
            held_off   = 1'b1;
            stall_left = HOLD_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            result_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 7);
            result_stall <= 1'b1;
        end else begin
            result_stall <= 1'b0;
        end
    end

    // Watchdog: any accepted request, result or register write counts as
    // progress; a long enough dry spell means the block has hung.
    always @(posedge clk) begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d results still owed",
                     $time, STALL_LIMIT, pending_symbols.size());
            $display("FAIL rans_byte_decoder_top");
            $finish;
        end
    end

    initial begin
        symbol_out_t typed_out;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_PLANE_LEN) begin
                write_plane_length(directed_rows[i].cfg_val);
            end else begin
                typed_out.sym    = directed_rows[i].e_sym;
                typed_out.refill = directed_rows[i].e_refill;
                typed_out.last   = directed_rows[i].e_last;
                send_request(make_request(directed_rows[i].op, directed_rows[i].sym,
                                          directed_rows[i].freq, directed_rows[i].cum,
                                          directed_rows[i].sbyte),
                             directed_rows[i].typed, typed_out);
            end
        end

        // Mostly well-formed planes with random content, the rest noise.
        while (requests_sent < TARGET_REQUESTS) begin
            if ($urandom_range(0, 9) < 8)
                play_plane();
            else
                repeat ($urandom_range(3, 10)) send_noise();
        end

        item_valid <= 1'b0;
        while (pending_symbols.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d requests: %0d loads, %0d bytes, %0d decodes (%0d refused), %0d unknown.",
                 requests_sent, loads_seen, bytes_seen, decodes_seen, refused_seen, others_seen);
        $display("Saw %0d plane ends and %0d refill flags over %0d plane lengths; %0d mismatches.",
                 lasts_seen, refills_seen, plane_writes, mismatches);
        if (mismatches == 0)
            $display("PASS rans_byte_decoder_top");
        else
            $display("FAIL rans_byte_decoder_top");
        $finish;
    end

endmodule
